[src/vcds_pkg.sv]
package vcds_pkg;

    localparam int VERTEX_W         = 6;
    localparam int MAX_COVER_W      = 7;
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;
    localparam int QUEUE_DEPTH      = 4;

    // command from the front to the search engine
    typedef struct packed {
        logic [VERTEX_W-1:0] a;
        logic [VERTEX_W-1:0] b;
        logic                load;
        logic                start;
    } cmd_t;

    typedef enum logic [1:0] {
        BR_SKIP = 2'd0,
        BR_A    = 2'd1,
        BR_B    = 2'd2
    } branch_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DESC,
        ST_DESC_EVAL,
        ST_BACK,
        ST_BACK_EVAL
    } search_state_t;

endpackage

[src/vertex_cover_decision_search.sv]
// Edge items are taken one per cycle into a 4-entry command queue while it is not
// full; the engine stores one edge per cycle while idle. The last item starts a
// depth-first search whose descend steps (ST_DESC, ST_DESC_EVAL) and backtrack
// steps (ST_BACK, ST_BACK_EVAL) wait on registered edge and branch memory reads,
// then registers the verdict: latency grows with the search tree. Async active-low
// reset clears control, counts and marks; edge and branch memories are not cleared.
module vertex_cover_decision_search #(
    parameter int MAX_VERTICES = vcds_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = vcds_pkg::DEF_MAX_EDGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [vcds_pkg::VERTEX_W-1:0]     vertex_a,
    input  logic [vcds_pkg::VERTEX_W-1:0]     vertex_b,
    input  logic                              has_edge,
    input  logic                              last_edge,
    output logic                              empty,
    input  logic                              pop,
    output logic                              cover_found,
    input  logic                              max_cover_we,
    input  logic [vcds_pkg::MAX_COVER_W-1:0]  max_cover
);
    import vcds_pkg::*;

    logic q_full;
    logic q_wr;
    cmd_t q_wcmd;
    cmd_t q_rcmd;
    logic q_valid;
    logic q_pop;

    vcds_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .push      (push),
        .full      (full),
        .vertex_a  (vertex_a),
        .vertex_b  (vertex_b),
        .has_edge  (has_edge),
        .last_edge (last_edge),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_cmd     (q_wcmd)
    );

    vcds_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wcmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rcmd),
        .valid   (q_valid)
    );

    vcds_search #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (max_cover_we),
        .cfg_data    (max_cover),
        .cmd_valid   (q_valid),
        .cmd         (q_rcmd),
        .cmd_pop     (q_pop),
        .empty       (empty),
        .pop         (pop),
        .cover_found (cover_found)
    );

endmodule

[src/vcds_front.sv]
module vcds_front #(
    parameter int MAX_VERTICES = vcds_pkg::DEF_MAX_VERTICES
) (
    input  logic                           push,
    output logic                           full,
    input  logic [vcds_pkg::VERTEX_W-1:0]  vertex_a,
    input  logic [vcds_pkg::VERTEX_W-1:0]  vertex_b,
    input  logic                           has_edge,
    input  logic                           last_edge,
    input  logic                           q_full,
    output logic                           q_wr,
    output vcds_pkg::cmd_t                 q_cmd
);
    import vcds_pkg::*;

    localparam int TBL_N = 2 ** VERTEX_W;

    logic [VERTEX_W-1:0] mod_tbl [TBL_N];
    logic                accept;

    // vertex index folded into range, built at elaboration
    always_comb
    begin
        for (int i = 0; i < TBL_N; i++)
        begin
            mod_tbl[i] = VERTEX_W'(i % MAX_VERTICES);
        end
    end

    assign full   = q_full;
    assign accept = push & ~q_full;

    // items with neither an edge nor the last mark are dropped here
    assign q_wr        = accept & (has_edge | last_edge);
    assign q_cmd.a     = mod_tbl[vertex_a];
    assign q_cmd.b     = mod_tbl[vertex_b];
    assign q_cmd.load  = has_edge;
    assign q_cmd.start = last_edge;

endmodule

[src/vcds_queue.sv]
module vcds_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  vcds_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output vcds_pkg::cmd_t rd_data,
    output logic           valid
);
    import vcds_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t            mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_wr, do_rd;

    assign full    = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(do_wr) - (PW+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/vcds_search.sv]
module vcds_search #(
    parameter int MAX_VERTICES = vcds_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = vcds_pkg::DEF_MAX_EDGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vcds_pkg::MAX_COVER_W-1:0]  cfg_data,
    input  logic                              cmd_valid,
    input  vcds_pkg::cmd_t                    cmd,
    output logic                              cmd_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic                              cover_found
);
    import vcds_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);

    search_state_t          state_reg, state_next;
    logic [CW-1:0]          total_reg, total_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          pos_m1;
    logic [MAX_COVER_W-1:0] count_reg, count_next;
    logic [MAX_COVER_W-1:0] max_cover_reg;
    logic [MAX_VERTICES-1:0] marks_reg, marks_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_reg, res_next;

    logic [2*VW-1:0]        edge_mem [MAX_EDGES];
    branch_t                br_mem [MAX_EDGES];
    logic [2*VW-1:0]        edge_rd_reg;
    branch_t                br_rd_reg;

    logic                   edge_we;
    logic [AW-1:0]          rd_addr;
    logic                   br_we;
    logic [AW-1:0]          br_waddr;
    branch_t                br_wdata;
    logic                   verdict;
    logic                   verdict_val;
    logic [VW-1:0]          ea, eb;
    logic                   over;
    logic                   at_end;

    assign ea     = edge_rd_reg[2*VW-1:VW];
    assign eb     = edge_rd_reg[VW-1:0];
    assign pos_m1 = pos_reg - 1'b1;
    assign over   = (count_reg > max_cover_reg);
    assign at_end = (pos_reg >= total_reg);

    assign empty       = ~res_valid_reg;
    assign cover_found = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.start && !res_valid_reg)
                begin
                    state_next = ST_DESC;
                end
            end
            ST_DESC:
            begin
                priority if (over)
                begin
                    state_next = ST_BACK;
                end
                else if (at_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DESC_EVAL;
                end
            end
            ST_DESC_EVAL:
            begin
                state_next = ST_DESC;
            end
            ST_BACK:
            begin
                state_next = (pos_reg == '0) ? ST_IDLE : ST_BACK_EVAL;
            end
            ST_BACK_EVAL:
            begin
                state_next = (br_rd_reg == BR_A) ? ST_DESC : ST_BACK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop     = 1'b0;
        edge_we     = 1'b0;
        br_we       = 1'b0;
        br_wdata    = BR_SKIP;
        br_waddr    = pos_reg[AW-1:0];
        rd_addr     = pos_reg[AW-1:0];
        verdict     = 1'b0;
        verdict_val = 1'b0;
        total_next  = total_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        marks_next  = marks_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // a second graph start waits until the last verdict is taken
                if (cmd_valid && !(cmd.start && res_valid_reg))
                begin
                    cmd_pop = 1'b1;
                    if (cmd.load && (total_reg < CW'(MAX_EDGES)))
                    begin
                        edge_we    = 1'b1;
                        total_next = total_reg + 1'b1;
                    end
                    if (cmd.start)
                    begin
                        pos_next   = '0;
                        count_next = '0;
                    end
                end
            end
            ST_DESC:
            begin
                if (!over && at_end)
                begin
                    verdict     = 1'b1;
                    verdict_val = 1'b1;
                end
            end
            ST_DESC_EVAL:
            begin
                br_we = 1'b1;
                if (marks_reg[ea] || marks_reg[eb])
                begin
                    br_wdata = BR_SKIP;
                end
                else
                begin
                    br_wdata       = BR_A;
                    marks_next[ea] = 1'b1;
                    count_next     = count_reg + 1'b1;
                end
                pos_next = pos_reg + 1'b1;
            end
            ST_BACK:
            begin
                if (pos_reg == '0)
                begin
                    verdict     = 1'b1;
                    verdict_val = 1'b0;
                end
                else
                begin
                    pos_next = pos_m1;
                    rd_addr  = pos_m1[AW-1:0];
                end
            end
            ST_BACK_EVAL:
            begin
                unique case (br_rd_reg)
                    BR_A:
                    begin
                        marks_next[ea] = 1'b0;
                        marks_next[eb] = 1'b1;
                        br_we          = 1'b1;
                        br_wdata       = BR_B;
                        pos_next       = pos_reg + 1'b1;
                    end
                    BR_B:
                    begin
                        marks_next[eb] = 1'b0;
                        count_next     = count_reg - 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (verdict)
        begin
            total_next = '0;
            pos_next   = '0;
            count_next = '0;
            marks_next = '0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg & ~pop;
        res_next       = res_reg;
        if (verdict)
        begin
            res_valid_next = 1'b1;
            res_next       = verdict_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[total_reg[AW-1:0]] <= {cmd.a[VW-1:0], cmd.b[VW-1:0]};
        end
        edge_rd_reg <= edge_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (br_we)
        begin
            br_mem[br_waddr] <= br_wdata;
        end
        br_rd_reg <= br_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            marks_reg     <= '0;
            max_cover_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            marks_reg     <= marks_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                max_cover_reg <= cfg_data;
            end
        end
    end

endmodule

[tb/vertex_cover_decision_search_tb.sv]
`timescale 1ns / 1ps

class cover_verdict_board;
    logic [5:0] end_a [vcds_pkg::DEF_MAX_EDGES];
    logic [5:0] end_b [vcds_pkg::DEF_MAX_EDGES];
    int         stored = 0;
    logic [6:0] limit = '0;
    bit         verdicts_due [$];
    int         errors = 0;
    int         graphs = 0;
    int         covers_found = 0;

    function void set_limit(logic [6:0] value);
        limit = value;
    endfunction

    function int pending();
        return verdicts_due.size();
    endfunction

    // depth-first branching over stored edges, a-endpoint tried before b
    function bit bounded_cover_exists();
        vcds_pkg::branch_t path [vcds_pkg::DEF_MAX_EDGES];
        logic [63:0] marks;
        int pos;
        int chosen;
        bit going_down;
        bit done;
        bit verdict;
        marks = '0;
        pos = 0;
        chosen = 0;
        going_down = 1'b1;
        done = 1'b0;
        verdict = 1'b0;
        while (!done)
        begin
            if (going_down)
            begin
                if (chosen > limit)
                    going_down = 1'b0;
                else if (pos >= stored)
                begin
                    verdict = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    if (marks[end_a[pos]] || marks[end_b[pos]])
                        path[pos] = vcds_pkg::BR_SKIP;
                    else
                    begin
                        marks[end_a[pos]] = 1'b1;
                        path[pos] = vcds_pkg::BR_A;
                        chosen++;
                    end
                    pos++;
                end
            end
            else if (pos == 0)
                done = 1'b1;
            else
            begin
                pos--;
                if (path[pos] == vcds_pkg::BR_A)
                begin
                    // clear a before setting b so a self loop keeps its mark
                    marks[end_a[pos]] = 1'b0;
                    marks[end_b[pos]] = 1'b1;
                    path[pos] = vcds_pkg::BR_B;
                    pos++;
                    going_down = 1'b1;
                end
                else if (path[pos] == vcds_pkg::BR_B)
                begin
                    marks[end_b[pos]] = 1'b0;
                    chosen--;
                end
            end
        end
        return verdict;
    endfunction

    function void note_item(logic [5:0] a, logic [5:0] b, logic has, logic last);
        if (has && stored < vcds_pkg::DEF_MAX_EDGES)
        begin
            end_a[stored] = a;
            end_b[stored] = b;
            stored++;
        end
        if (last)
        begin
            verdicts_due.push_back(bounded_cover_exists());
            stored = 0;
        end
    endfunction

    function void check(logic found);
        bit want;
        if (verdicts_due.size() == 0)
        begin
            $error("cover_found: no verdict expected, actual %0b", found);
            errors++;
            return;
        end
        want = verdicts_due.pop_front();
        graphs++;
        if (want)
            covers_found++;
        if (found !== want)
        begin
            $error("cover_found mismatch: expected %0b, actual %0b", want, found);
            errors++;
        end
    endfunction
endclass

module vertex_cover_decision_search_tb;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [5:0] vertex_a = '0;
    logic [5:0] vertex_b = '0;
    logic       has_edge = 1'b0;
    logic       last_edge = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic       cover_found;
    logic       max_cover_we = 1'b0;
    logic [6:0] max_cover = '0;

    cover_verdict_board board = new();

    int send_idle_pct = 18;
    int recv_stall_pct = 81;
    int stim_items = 0;
    int limits [10] = '{0, 64, 1, 2, 3, 27, 4, 5, 40, 6};

    vertex_cover_decision_search dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .has_edge     (has_edge),
        .last_edge    (last_edge),
        .empty        (empty),
        .pop          (pop),
        .cover_found  (cover_found),
        .max_cover_we (max_cover_we),
        .max_cover    (max_cover)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(50_000_000);
        $display("FAIL vertex_cover_decision_search");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            board.note_item(vertex_a, vertex_b, has_edge, last_edge);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.check(cover_found);
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // push stays high from one item to the next unless an idle cycle is drawn
    task automatic send_item(input logic [5:0] a, input logic [5:0] b,
                             input logic has, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        vertex_a <= a;
        vertex_b <= b;
        has_edge <= has;
        last_edge <= last;
        do @(posedge clk); while (full);
        if (has || last)
            stim_items++;
    endtask

    task automatic set_cover(input int value);
        push <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        // edge-only items may still be draining from the command queue
        repeat (12) @(posedge clk);
        max_cover_we <= 1'b1;
        max_cover <= 7'(value);
        @(posedge clk);
        max_cover_we <= 1'b0;
        board.set_limit(7'(value));
    endtask

    // vertices drawn from a window of span+1 so cover sizes land near the limit
    task automatic send_graph(input int n_edges, input int span);
        int i;
        int base;
        bit tail_edge;
        logic [5:0] a;
        logic [5:0] b;
        base = $urandom_range(0, 63);
        tail_edge = (n_edges > 0) && ($urandom_range(0, 2) != 0);
        for (i = 0; i < n_edges; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0, 1'b0);
            a = 6'((base + $urandom_range(0, span)) % 64);
            b = 6'((base + $urandom_range(0, span)) % 64);
            send_item(a, b, 1'b1, tail_edge && (i == n_edges - 1));
        end
        if (!tail_edge)
            send_item(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0, 1'b1);
    endtask

    // more edges than the store holds; with a hub, the kept edges share one vertex
    task automatic send_overflow_graph(input bit hub);
        int i;
        int total;
        logic [5:0] center;
        total = vcds_pkg::DEF_MAX_EDGES + $urandom_range(1, 40);
        center = 6'($urandom_range(0, 63));
        for (i = 0; i < total; i++)
        begin
            if (hub && i < vcds_pkg::DEF_MAX_EDGES)
                send_item(center, 6'($urandom_range(0, 63)), 1'b1, 1'b0);
            else
                send_item(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b1,
                          i == total - 1);
        end
    endtask

    initial
    begin
        int mode;
        int p;
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limit still at its reset value of zero
        send_item(6'd0, 6'd0, 1'b0, 1'b1);
        send_item(6'd63, 6'd63, 1'b0, 1'b0);
        send_item(6'd63, 6'd0, 1'b1, 1'b1);

        set_cover(1);
        send_item(6'd5, 6'd5, 1'b1, 1'b1);
        send_item(6'd0, 6'd1, 1'b1, 1'b0);
        send_item(6'd1, 6'd2, 1'b1, 1'b0);
        send_item(6'd2, 6'd0, 1'b1, 1'b1);
        send_item(6'd42, 6'd21, 1'b0, 1'b1);
        // star centered on b: needs the second branch at the first edge
        send_item(6'd1, 6'd0, 1'b1, 1'b0);
        send_item(6'd2, 6'd0, 1'b1, 1'b0);
        send_item(6'd3, 6'd0, 1'b1, 1'b1);

        set_cover(2);
        send_item(6'd0, 6'd1, 1'b1, 1'b0);
        send_item(6'd1, 6'd2, 1'b1, 1'b0);
        send_item(6'd2, 6'd0, 1'b1, 1'b1);
        send_item(6'd1, 6'd2, 1'b1, 1'b0);
        send_item(6'd63, 6'd62, 1'b1, 1'b0);
        send_item(6'd21, 6'd42, 1'b0, 1'b1);

        set_cover(64);
        send_item(6'd0, 6'd63, 1'b1, 1'b0);
        send_item(6'd63, 6'd0, 1'b1, 1'b0);
        send_item(6'd42, 6'd21, 1'b1, 1'b1);

        for (mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 81 : 0;
            recv_stall_pct = (mode == 0) ? 81 : (mode == 1) ? 18 : 0;
            for (p = 0; p < 10; p++)
            begin
                set_cover(limits[p]);
                if (mode == 2 && limits[p] == 1)
                    send_overflow_graph(1'b1);
                if (mode == 2 && limits[p] == 64)
                    send_overflow_graph(1'b0);
                target = stim_items + 21;
                while (stim_items < target)
                begin
                    if (limits[p] <= 6)
                        send_graph($urandom_range(0, 10), $urandom_range(1, limits[p] + 4));
                    else
                        send_graph($urandom_range(0, 12), 63);
                end
            end
        end

        push <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d edge and closing items over %0d cover limits and three pacing modes.",
                 stim_items, 10);
        $display("Checked %0d verdicts: %0d with a cover, %0d without.",
                 board.graphs, board.covers_found, board.graphs - board.covers_found);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS vertex_cover_decision_search");
        else
            $display("FAIL vertex_cover_decision_search");
        $finish;
    end

endmodule
